>>> rtl/core/io_expander_command_parser_unit_macros.svh
// Assertion helpers shared by the parser core.
`ifndef IO_EXPANDER_COMMAND_PARSER_UNIT_MACROS_SVH
`define IO_EXPANDER_COMMAND_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IOEXP_ASSERT_IMP(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IOEXP_ASSERT_NXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/ioexp_pkg.sv
package ioexp_pkg;

    localparam int NUM_CHANNELS = 13;
    localparam int CH_IDX_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int OUT_DATA_W   = 64;

    // Stream bytes
    localparam logic [7:0] START_CODE = 8'hCE;
    localparam logic [7:0] CMD_SET    = 8'hF0;
    localparam logic [7:0] CMD_CFG    = 8'hF1;
    localparam logic [7:0] CMD_GET    = 8'hF2;
    localparam logic [7:0] CMD_RST    = 8'hF3;

    // Channel modes
    localparam logic [2:0] MD_NONE    = 3'd0;
    localparam logic [2:0] MD_PWM     = 3'd1;
    localparam logic [2:0] MD_AIN     = 3'd2;
    localparam logic [2:0] MD_SINGLE  = 3'd3;
    localparam logic [2:0] MD_MULTI   = 3'd4;
    localparam logic [2:0] MD_DIN     = 3'd5;
    localparam logic [2:0] MD_DOUT    = 3'd6;
    localparam logic [2:0] MD_INVALID = 3'd7;

    // Actions
    localparam logic [2:0] ACT_CONFIG = 3'd0;
    localparam logic [2:0] ACT_PWM    = 3'd1;
    localparam logic [2:0] ACT_DWRITE = 3'd2;
    localparam logic [2:0] ACT_FILL   = 3'd3;
    localparam logic [2:0] ACT_SETLED = 3'd4;
    localparam logic [2:0] ACT_READ   = 3'd5;
    localparam logic [2:0] ACT_RESET  = 3'd6;

    // Pin mapping limits
    localparam logic [7:0] LAST_PIN_CHAN = 8'd12;
    localparam logic [7:0] NO_PIN_CHAN   = 8'd5;

    typedef struct packed {
        logic       rd_en;
        logic [7:0] rd_chan;
        logic       wr_en;
        logic [7:0] wr_chan;
        logic [2:0] wr_mode;
        logic [7:0] wr_count;
        logic       clr;
    } tbl_req_t;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] count;
    } tbl_rsp_t;

    typedef struct packed {
        logic [2:0] action;
        logic [3:0] chan;
        logic [4:0] pin_number;
        logic       pin_valid;
        logic [2:0] chan_mode;
        logic [7:0] level;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] led_index;
        logic [7:0] led_total;
        logic       sync_now;
    } result_t;

    typedef struct packed {
        logic [4:0] num;
        logic       valid;
    } pin_t;

    function automatic pin_t pin_of(input logic [7:0] ch);
        pin_t p;
        p.valid = (ch <= LAST_PIN_CHAN) && (ch != NO_PIN_CHAN);
        case (ch[3:0])
            4'd0:    p.num = 5'd10;
            4'd1:    p.num = 5'd9;
            4'd2:    p.num = 5'd6;
            4'd3:    p.num = 5'd5;
            4'd4:    p.num = 5'd15;
            4'd6:    p.num = 5'd2;
            4'd7:    p.num = 5'd11;
            4'd8:    p.num = 5'd16;
            4'd9:    p.num = 5'd3;
            4'd10:   p.num = 5'd17;
            4'd11:   p.num = 5'd8;
            4'd12:   p.num = 5'd7;
            default: p.num = 5'd0;
        endcase
        if (!p.valid)
        begin
            p.num = 5'd0;
        end
        return p;
    endfunction

endpackage

>>> rtl/core/ioexp_chan_table.sv
module ioexp_chan_table (
    input  logic               clk,
    input  logic               rst_n,
    input  ioexp_pkg::tbl_req_t req,
    output ioexp_pkg::tbl_rsp_t rsp
);
    import ioexp_pkg::*;

    logic [10:0]             mem [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] valid_reg;
    logic [NUM_CHANNELS-1:0] valid_next;
    logic                    hit_reg;
    logic                    hit_next;
    logic [10:0]             word_reg;
    logic [CH_IDX_W-1:0]     wr_idx;
    logic [CH_IDX_W-1:0]     rd_idx;
    logic                    wr_in;
    logic                    rd_in;
    logic                    fwd;
    logic [10:0]             wr_word;

    assign wr_idx  = req.wr_chan[CH_IDX_W-1:0];
    assign rd_idx  = req.rd_chan[CH_IDX_W-1:0];
    assign wr_in   = req.wr_en && (req.wr_chan < 8'(NUM_CHANNELS));
    assign rd_in   = req.rd_chan < 8'(NUM_CHANNELS);
    assign fwd     = wr_in && (req.wr_chan == req.rd_chan);
    assign wr_word = {req.wr_mode, req.wr_count};

    always_comb
    begin
        valid_next = valid_reg;
        if (req.clr)
        begin
            valid_next = '0;
        end
        else if (wr_in)
        begin
            valid_next[wr_idx] = 1'b1;
        end
    end

    // A clear or a write in the same cycle wins over the stored entry.
    assign hit_next = !req.clr && (fwd || (rd_in && valid_reg[rd_idx]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (req.rd_en)
            begin
                hit_reg <= hit_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_in)
        begin
            mem[wr_idx] <= wr_word;
        end
        if (req.rd_en)
        begin
            word_reg <= fwd ? wr_word : mem[rd_idx];
        end
    end

    assign rsp.mode  = hit_reg ? word_reg[10:8] : MD_INVALID;
    assign rsp.count = hit_reg ? word_reg[7:0] : 8'd0;

endmodule

>>> rtl/core/ioexp_parser.sv
`include "io_expander_command_parser_unit_macros.svh"

module ioexp_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s1_valid,
    input  logic                s1_func,
    input  logic [7:0]          s1_byte,
    input  logic                fire,
    input  logic                accept,
    input  logic [7:0]          in_byte,
    input  ioexp_pkg::tbl_rsp_t rsp,
    output ioexp_pkg::tbl_req_t req,
    output logic                res_valid,
    output ioexp_pkg::result_t  res
);
    import ioexp_pkg::*;

    localparam logic [3:0] PS_CMD      = 4'd0;
    localparam logic [3:0] PS_CFG_CHAN = 4'd1;
    localparam logic [3:0] PS_CFG_MODE = 4'd2;
    localparam logic [3:0] PS_SET_CHAN = 4'd3;
    localparam logic [3:0] PS_GET_CHAN = 4'd4;
    localparam logic [3:0] PS_OFFSET   = 4'd5;
    localparam logic [3:0] PS_SINGLE   = 4'd6;
    localparam logic [3:0] PS_RED      = 4'd7;
    localparam logic [3:0] PS_GREEN    = 4'd8;
    localparam logic [3:0] PS_BLUE     = 4'd9;
    localparam logic [3:0] PS_COUNT    = 4'd10;
    localparam logic [3:0] PS_WAIT     = 4'd15;

    logic [3:0] ps_reg,     ps_next;
    logic [7:0] cur_reg,    cur_next;
    logic [7:0] cursor_reg, cursor_next;
    logic [7:0] red_reg,    red_next;
    logic [7:0] green_reg,  green_next;
    logic [3:0] ps_after;
    logic [7:0] cur_after;
    logic [7:0] cursor_inc;
    logic       cur_in_range;
    logic       wr_en_c;
    logic       clr_c;
    logic [2:0] wr_mode_c;
    logic [7:0] wr_count_c;

    function automatic result_t base(input logic [2:0] act, input logic [7:0] ch,
                                     input logic [2:0] md);
        result_t r;
        pin_t    p;
        p            = pin_of(ch);
        r            = '0;
        r.action     = act;
        r.chan       = ch[3:0];
        r.pin_number = p.num;
        r.pin_valid  = p.valid;
        r.chan_mode  = md;
        return r;
    endfunction

    assign cursor_inc   = cursor_reg + 8'd1;
    assign cur_in_range = cur_reg < 8'(NUM_CHANNELS);

    always_comb
    begin
        ps_next     = ps_reg;
        cur_next    = cur_reg;
        cursor_next = cursor_reg;
        red_next    = red_reg;
        green_next  = green_reg;
        res_valid   = 1'b0;
        res         = '0;
        wr_en_c     = 1'b0;
        clr_c       = 1'b0;
        wr_mode_c   = rsp.mode;
        wr_count_c  = rsp.count;
        if (s1_valid)
        begin
            if (s1_func)
            begin
                ps_next = PS_WAIT;
            end
            else
            begin
                case (ps_reg)
                    PS_CMD:
                    begin
                        if (s1_byte == CMD_SET)
                        begin
                            ps_next = PS_SET_CHAN;
                        end
                        else if (s1_byte == CMD_GET)
                        begin
                            ps_next = PS_GET_CHAN;
                        end
                        else if (s1_byte == CMD_CFG)
                        begin
                            ps_next = PS_CFG_CHAN;
                        end
                        else if (s1_byte == CMD_RST)
                        begin
                            ps_next     = PS_WAIT;
                            cur_next    = 8'd0;
                            cursor_next = 8'd0;
                            red_next    = 8'd0;
                            green_next  = 8'd0;
                            clr_c       = 1'b1;
                            res_valid   = 1'b1;
                            res.action  = ACT_RESET;
                        end
                    end
                    PS_SET_CHAN, PS_GET_CHAN, PS_CFG_CHAN:
                    begin
                        cur_next = s1_byte;
                        if (ps_reg == PS_CFG_CHAN)
                        begin
                            ps_next = PS_CFG_MODE;
                        end
                        else if (rsp.mode inside {MD_PWM, MD_DOUT})
                        begin
                            ps_next = PS_SINGLE;
                        end
                        else if (rsp.mode == MD_SINGLE)
                        begin
                            ps_next = PS_RED;
                        end
                        else if (rsp.mode == MD_MULTI)
                        begin
                            ps_next = PS_OFFSET;
                        end
                        else if (rsp.mode inside {MD_DIN, MD_AIN})
                        begin
                            if (ps_reg == PS_SET_CHAN)
                            begin
                                ps_next = PS_SINGLE;
                            end
                            else
                            begin
                                ps_next   = PS_CMD;
                                res_valid = 1'b1;
                                res       = base(ACT_READ, s1_byte, rsp.mode);
                            end
                        end
                    end
                    PS_CFG_MODE:
                    begin
                        wr_mode_c = s1_byte[2:0];
                        if (s1_byte > {5'd0, MD_DOUT})
                        begin
                            ps_next = PS_WAIT;
                        end
                        else if (s1_byte[2:0] inside {MD_SINGLE, MD_MULTI})
                        begin
                            ps_next = PS_COUNT;
                            wr_en_c = 1'b1;
                        end
                        else
                        begin
                            ps_next = PS_WAIT;
                            wr_en_c = 1'b1;
                            if (cur_in_range)
                            begin
                                res_valid     = 1'b1;
                                res           = base(ACT_CONFIG, cur_reg, s1_byte[2:0]);
                                res.led_total = rsp.count;
                            end
                        end
                    end
                    PS_COUNT:
                    begin
                        ps_next    = PS_WAIT;
                        wr_count_c = s1_byte;
                        wr_en_c    = 1'b1;
                        if (cur_in_range)
                        begin
                            res_valid     = 1'b1;
                            res           = base(ACT_CONFIG, cur_reg, rsp.mode);
                            res.led_total = s1_byte;
                        end
                    end
                    PS_OFFSET:
                    begin
                        cursor_next = s1_byte;
                        ps_next     = PS_RED;
                    end
                    PS_SINGLE:
                    begin
                        ps_next = PS_WAIT;
                        if (rsp.mode == MD_PWM)
                        begin
                            res_valid = 1'b1;
                            res       = base(ACT_PWM, cur_reg, rsp.mode);
                            res.level = s1_byte;
                        end
                        else if (rsp.mode inside {MD_DOUT, MD_DIN, MD_AIN})
                        begin
                            res_valid = 1'b1;
                            res       = base(ACT_DWRITE, cur_reg, rsp.mode);
                            res.level = s1_byte;
                        end
                    end
                    PS_RED:
                    begin
                        red_next = s1_byte;
                        ps_next  = PS_GREEN;
                    end
                    PS_GREEN:
                    begin
                        green_next = s1_byte;
                        ps_next    = PS_BLUE;
                    end
                    PS_BLUE:
                    begin
                        ps_next = PS_WAIT;
                        if (rsp.mode == MD_SINGLE)
                        begin
                            res_valid     = 1'b1;
                            res           = base(ACT_FILL, cur_reg, rsp.mode);
                            res.red       = red_reg;
                            res.green     = green_reg;
                            res.blue      = s1_byte;
                            res.led_total = rsp.count;
                            res.sync_now  = 1'b1;
                        end
                        else if (rsp.mode == MD_MULTI)
                        begin
                            res_valid     = 1'b1;
                            res           = base(ACT_SETLED, cur_reg, rsp.mode);
                            res.red       = red_reg;
                            res.green     = green_reg;
                            res.blue      = s1_byte;
                            res.led_index = cursor_reg;
                            res.sync_now  = cursor_inc >= rsp.count;
                            cursor_next   = cursor_inc;
                            // Keep streaming until the string ends or a block of 8 closes.
                            if (!(cursor_inc >= rsp.count || cursor_inc[2:0] == 3'd0))
                            begin
                                ps_next = PS_RED;
                            end
                        end
                    end
                    default:
                    begin
                        if (s1_byte == START_CODE)
                        begin
                            ps_next = PS_CMD;
                        end
                    end
                endcase
            end
        end
    end

    // Address of the next read: the incoming byte names the channel in the
    // channel states, otherwise the current channel (both after this update).
    assign ps_after  = fire ? ps_next : ps_reg;
    assign cur_after = fire ? cur_next : cur_reg;

    always_comb
    begin
        req.rd_en    = accept;
        req.rd_chan  = (ps_after == PS_SET_CHAN || ps_after == PS_GET_CHAN ||
                        ps_after == PS_CFG_CHAN) ? in_byte : cur_after;
        req.wr_en    = fire && wr_en_c;
        req.wr_chan  = cur_reg;
        req.wr_mode  = wr_mode_c;
        req.wr_count = wr_count_c;
        req.clr      = fire && clr_c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ps_reg     <= PS_WAIT;
            cur_reg    <= 8'd0;
            cursor_reg <= 8'd0;
            red_reg    <= 8'd0;
            green_reg  <= 8'd0;
        end
        else if (fire)
        begin
            ps_reg     <= ps_next;
            cur_reg    <= cur_next;
            cursor_reg <= cursor_next;
            red_reg    <= red_next;
            green_reg  <= green_next;
        end
    end

    `IOEXP_ASSERT_IMP(a_pin_none_ch5, clk, rst_n, res_valid && res.pin_valid, res.chan != 4'd5, "pin reported for unmapped channel")
    `IOEXP_ASSERT_NXT(a_timeout_wait, clk, rst_n, fire && s1_func, ps_reg == PS_WAIT, "timeout did not return parser to waiting")

endmodule

>>> rtl/core/io_expander_command_parser_unit.sv
// A result reaches m_axis through the execute stage and then the output register.
// Throughput: one request per cycle unless execute stalls; the channel table
// is read on accept and written back in execute, with write-first forwarding.
// Reset (rst_n low, asynchronous): pipeline and output empty, parser waits for
// the start byte, every channel reads as invalid mode with an LED count of zero.
`include "io_expander_command_parser_unit_macros.svh"

module io_expander_command_parser_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,  // [7:0] data_byte
    input  logic                              s_axis_tuser,  // [0] func
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [3:0] chan, [8:4] pin_number, [9] pin_valid, [12:10] chan_mode,
    // [20:13] level, [28:21] red, [36:29] green, [44:37] blue,
    // [52:45] led_index, [60:53] led_total, [61] sync_now, [63:62] zero
    output logic [ioexp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic [2:0]                        m_axis_tuser   // [2:0] action
);
    import ioexp_pkg::*;

    // Execute stage: holds the request whose channel table read is in flight.
    logic       s1_valid_reg;
    logic       s1_valid_next;
    logic       s1_func_reg;
    logic [7:0] s1_byte_reg;

    // Output register: parts the result side from the request side.
    logic       out_valid_reg;
    logic       out_valid_next;
    result_t    out_res_reg;

    logic       s_accept;
    logic       out_free;
    logic       s1_fire;
    logic       res_valid;
    result_t    res;
    tbl_req_t   tbl_req;
    tbl_rsp_t   tbl_rsp;

    // Advance the execute stage when the request gives no result, or when the
    // output register is free or being drained this cycle.
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s1_fire       = s1_valid_reg && (!res_valid || out_free);
    assign s_axis_tready = !s1_valid_reg || s1_fire;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // Channel table: one read port (issued on accept), one write port.
    ioexp_chan_table u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (tbl_req),
        .rsp   (tbl_rsp)
    );

    // Parser: state registers and the step for the request in the execute stage.
    ioexp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .s1_valid  (s1_valid_reg),
        .s1_func   (s1_func_reg),
        .s1_byte   (s1_byte_reg),
        .fire      (s1_fire),
        .accept    (s_accept),
        .in_byte   (s_axis_tdata),
        .rsp       (tbl_rsp),
        .req       (tbl_req),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_fire && res_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: load the request on accept, the result when it leaves execute.
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_func_reg <= s_axis_tuser;
            s1_byte_reg <= s_axis_tdata;
        end
        if (s1_fire && res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_res_reg.action;
    assign m_axis_tdata  = {2'b00,
                            out_res_reg.sync_now,
                            out_res_reg.led_total,
                            out_res_reg.led_index,
                            out_res_reg.blue,
                            out_res_reg.green,
                            out_res_reg.red,
                            out_res_reg.level,
                            out_res_reg.chan_mode,
                            out_res_reg.pin_valid,
                            out_res_reg.pin_number,
                            out_res_reg.chan};

    `IOEXP_ASSERT_IMP(a_reset_zero, clk, rst_n, m_axis_tvalid && m_axis_tuser == ACT_RESET, m_axis_tdata == '0, "reset action carries nonzero fields")
    `IOEXP_ASSERT_NXT(a_accept_fill, clk, rst_n, s_accept, s1_valid_reg, "accepted request not held in execute stage")
    `IOEXP_ASSERT_IMP(a_no_result_go, clk, rst_n, s1_valid_reg && !res_valid, s1_fire, "request without result stalled")

endmodule
